// ----- sv/lcpc_pkg.sv -----
// Package for the loop current pressure conditioner.
// Types, register indexes, FSM states and fixed-point constants.
// No dependencies.
package lcpc_pkg;

  localparam int unsigned CHANNELS_DEF = 6;

  localparam int unsigned MUL_A_W = 35;
  localparam int unsigned MUL_B_W = 25;
  localparam int unsigned MUL_HI_W = 36;
  localparam int unsigned MUL_P_W = MUL_HI_W + MUL_B_W;
  localparam int unsigned CFG_W = 24;

  localparam logic signed [33:0] MA_LOW  = 34'sd196608;
  localparam logic signed [33:0] MA_HIGH = 34'sd1376256;
  localparam logic signed [34:0] MA_ZERO = 35'sd262144;
  localparam logic [29:0] GAUGE_MAX = 30'h0FF_FFFF;

  typedef enum logic [2:0] {
    REG_ALPHA = 3'd0,
    REG_MA_PER_CODE = 3'd1,
    REG_P_LOW = 3'd2,
    REG_P_HIGH = 3'd3,
    REG_ATM = 3'd4
  } lcpc_reg_t;

  typedef enum logic [1:0] {
    BAND_UNDER = 2'd0,
    BAND_SPAN = 2'd1,
    BAND_OVER = 2'd2
  } lcpc_band_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT,
    ST_CURR,
    ST_PRES,
    ST_OUT
  } lcpc_state_t;

  typedef struct packed {
    logic [2:0] channel;
    logic signed [15:0] raw_code;
  } lcpc_in_t;

  typedef struct packed {
    logic [2:0] out_channel;
    logic [23:0] gauge_pressure;
    logic signed [23:0] loop_milliamps;
    logic [1:0] range_band;
  } lcpc_out_t;

  typedef struct packed {
    logic start;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } lcpc_mul_req_t;

endpackage

// ----- sv/loop_current_pressure_conditioner_unit.sv -----
// Top level of the loop current pressure conditioner: config registers,
// per-channel average store, sequencer and output register.
// Depends on lcpc_pkg and lcpc_mul.
//
// channel | valid     | ready     | data
// in      | in_valid  | in_ready  | in_data (lcpc_in_t)
// out     | out_valid | out_ready | out_data (lcpc_out_t)
// cfg     | cfg_wr_en | -         | cfg_index, cfg_data
//
// Each request runs three products on the shared bit-serial multiplier
// (filter, current, span), each with its done step, then the output step;
// in_ready stays low until the output step is through. Under- or over-range
// current skips the span product; a channel out of range skips all products.
// Reset is synchronous and clears the averages.
// A result waiting in the output register stalls only the final step.
module loop_current_pressure_conditioner_unit import lcpc_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  lcpc_in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output lcpc_out_t out_data,
  input  logic cfg_wr_en,
  input  logic [2:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [15:0] alpha_r;
  logic [23:0] mpc_r, plow_r, phigh_r, atm_r;

  logic signed [33:0] fmem_r [CHANNELS];
  logic signed [33:0] fmem_wdata;
  logic fmem_we;

  lcpc_state_t state_r, state_nxt;
  logic [2:0] ch_r, ch_nxt;
  logic signed [33:0] f_r, f_nxt;
  logic signed [33:0] ma_r, ma_nxt;
  logic [1:0] band_r, band_nxt;
  logic signed [28:0] abs_r, abs_nxt;
  logic out_valid_r, out_valid_nxt;
  lcpc_out_t out_r, out_nxt;

  lcpc_mul_req_t mreq;
  logic mdone;
  logic signed [MUL_P_W-1:0] mprod;

  logic in_acc, ch_ok;
  logic [CH_W-1:0] in_idx, idx_r;
  logic signed [33:0] f_in, f_new, ma_new;
  logic signed [34:0] diff;
  logic signed [24:0] span;
  logic signed [29:0] gauge;
  logic [23:0] gauge_sat;
  logic signed [23:0] ma_sat;

  lcpc_mul u_mul (
    .clk(clk),
    .rst_n(rst_n),
    .req(mreq),
    .done(mdone),
    .prod(mprod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= 16'd6554;
      mpc_r <= 24'd13981;
      plow_r <= 24'd0;
      phigh_r <= 24'd40960;
      atm_r <= 24'd4150;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ALPHA: alpha_r <= cfg_data[15:0];
        REG_MA_PER_CODE: mpc_r <= cfg_data;
        REG_P_LOW: plow_r <= cfg_data;
        REG_P_HIGH: phigh_r <= cfg_data;
        REG_ATM: atm_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc = in_valid && in_ready;
  assign in_idx = CH_W'(in_data.channel);
  assign idx_r = CH_W'(ch_r);
  assign ch_ok = (32'(in_data.channel) < CHANNELS);
  assign f_in = ch_ok ? fmem_r[in_idx] : '0;
  assign diff = (35'(in_data.raw_code) <<< 16) - 35'(f_in);
  assign f_new = f_r + mprod[49:16];
  assign ma_new = mprod[57:24];
  assign span = 25'(phigh_r) - 25'(plow_r);

  always_comb begin
    gauge = 30'(abs_r) - 30'(atm_r);
    if (gauge < 0) begin
      gauge_sat = '0;
    end else if (gauge > $signed(GAUGE_MAX)) begin
      gauge_sat = '1;
    end else begin
      gauge_sat = gauge[23:0];
    end
    if (ma_r > 34'sd8388607) begin
      ma_sat = 24'sh7F_FFFF;
    end else if (ma_r < -34'sd8388608) begin
      ma_sat = 24'sh80_0000;
    end else begin
      ma_sat = ma_r[23:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt = ch_r;
    f_nxt = f_r;
    ma_nxt = ma_r;
    band_nxt = band_r;
    abs_nxt = abs_r;
    out_valid_nxt = out_valid_r;
    out_nxt = out_r;
    mreq = '{start: 1'b0, a: '0, b: '0};
    fmem_we = 1'b0;
    fmem_wdata = f_new;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ch_nxt = in_data.channel;
          f_nxt = f_in;
          if (ch_ok) begin
            mreq = '{start: 1'b1, a: diff, b: 25'(alpha_r)};
            state_nxt = ST_FILT;
          end else begin
            ma_nxt = '0;
            band_nxt = BAND_UNDER;
            abs_nxt = '0;
            state_nxt = ST_OUT;
          end
        end
      end
      ST_FILT: begin
        if (mdone) begin
          fmem_we = 1'b1;
          mreq = '{start: 1'b1, a: 35'(f_new), b: 25'(mpc_r)};
          state_nxt = ST_CURR;
        end
      end
      ST_CURR: begin
        if (mdone) begin
          ma_nxt = ma_new;
          if (ma_new < MA_LOW) begin
            band_nxt = BAND_UNDER;
            abs_nxt = '0;
            state_nxt = ST_OUT;
          end else if (ma_new > MA_HIGH) begin
            band_nxt = BAND_OVER;
            abs_nxt = 29'(phigh_r);
            state_nxt = ST_OUT;
          end else begin
            band_nxt = BAND_SPAN;
            mreq = '{start: 1'b1, a: 35'(ma_new) - MA_ZERO, b: span};
            state_nxt = ST_PRES;
          end
        end
      end
      ST_PRES: begin
        if (mdone) begin
          abs_nxt = 29'(plow_r) + 29'($signed(mprod[47:20]));
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{out_channel: ch_r, gauge_pressure: gauge_sat,
                      loop_milliamps: ma_sat, range_band: band_r};
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        fmem_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fmem_we) begin
        fmem_r[idx_r] <= fmem_wdata;
      end
    end
    ch_r <= ch_nxt;
    f_r <= f_nxt;
    ma_r <= ma_nxt;
    band_r <= band_nxt;
    abs_r <= abs_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule

// ----- sv/lcpc_mul.sv -----
// Bit-serial signed multiplier, one multiplier bit per cycle, LSB first.
// Depends on lcpc_pkg.
module lcpc_mul import lcpc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  lcpc_mul_req_t req,
  output logic done,
  output logic signed [MUL_P_W-1:0] prod
);

  localparam int unsigned CNT_W = $clog2(MUL_B_W);

  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic signed [MUL_A_W-1:0] a_r, a_nxt;
  logic [MUL_B_W-1:0] b_r, b_nxt;
  logic signed [MUL_HI_W-1:0] hi_r, hi_nxt;
  logic [MUL_B_W-1:0] lo_r, lo_nxt;
  logic signed [MUL_HI_W-1:0] a_ext, addend, sum;
  logic last;

  always_comb begin
    a_ext = MUL_HI_W'(a_r);
    last = (cnt_r == CNT_W'(MUL_B_W - 1));
    addend = '0;
    if (b_r[0]) begin
      addend = last ? -a_ext : a_ext;
    end
    sum = hi_r + addend;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    a_nxt = a_r;
    b_nxt = b_r;
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      a_nxt = req.a;
      b_nxt = req.b;
      hi_nxt = '0;
      lo_nxt = '0;
    end else if (busy_r) begin
      hi_nxt = {sum[MUL_HI_W-1], sum[MUL_HI_W-1:1]};
      lo_nxt = {sum[0], lo_r[MUL_B_W-1:1]};
      b_nxt = {1'b0, b_r[MUL_B_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

// ----- sv/lcpc_checker.sv -----
// Port-level checker for the loop current pressure conditioner, with bind.
// Depends on lcpc_pkg and loop_current_pressure_conditioner_unit.
module lcpc_checker import lcpc_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input lcpc_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a request");

  a_under_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.range_band == BAND_UNDER |-> out_data.gauge_pressure == 24'd0)
    else $error("nonzero pressure under range");

  a_bad_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && 32'(out_data.out_channel) >= CHANNELS |->
      out_data.loop_milliamps == 24'sd0 && out_data.range_band == BAND_UNDER)
    else $error("bad channel gave a nonzero result");

endmodule

bind loop_current_pressure_conditioner_unit lcpc_checker #(.CHANNELS(CHANNELS)) u_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data(out_data)
);
